>>> sv/gnpa_pkg.sv
// Package for the greedy nearest point assignment block.
// Holds sizes, item codes, control structs and the coordinate helper.
// Depends on nothing; every other file of the block but gnpa_ram uses it.
`timescale 1ns / 1ps

package gnpa_pkg;

  // Store depth and internal coordinate width.
  localparam int TARGET_DEPTH = 2048;
  localparam int COORD_WIDTH  = 16;

  // Fixed field widths of the channels and the count register.
  localparam int FUNC_W        = 2;
  localparam int SLOT_W        = 11;
  localparam int FIELD_COORD_W = 16;
  localparam int DIST_W        = 34;
  localparam int COUNT_W       = 12;

  // Derived widths.
  localparam int ADDR_W = $clog2(TARGET_DEPTH);
  localparam int CNT_W  = $clog2(TARGET_DEPTH + 1);
  localparam int PT_W   = 3 * COORD_WIDTH;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int EXT_W  = (COORD_WIDTH > FIELD_COORD_W) ? COORD_WIDTH : FIELD_COORD_W;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MATCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pt_wr;     // write the item's point into the store
    logic ctr_clr;   // restart the address counter
    logic ctr_inc;   // step the address counter
    logic src_load;  // capture the source point and restart the best search
    logic issue;     // read one target into the distance pipeline
    logic used_clr;  // clear the used mark at the counter address
    logic mark;      // set the used mark of the best target
    logic out_load;  // load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // counter at the last store entry
    logic scan_last;   // counter at the last target of the scan
    logic limit_zero;  // no target takes part in matching
    logic pipe_busy;   // distance pipeline still holds targets
    logic out_free;    // result register can take a new item
    logic have;        // an unused target has been found
  } dp_status_t;

  // Sign-extend a coordinate field and keep COORD_WIDTH bits of it.
  function automatic logic signed [COORD_WIDTH-1:0] sext_coord(
      input logic [FIELD_COORD_W-1:0] raw);
    logic signed [EXT_W-1:0] wide;
    wide = EXT_W'(signed'(raw));
    return wide[COORD_WIDTH-1:0];
  endfunction

endpackage

>>> sv/gnpa_if.sv
// Channel interfaces of the greedy nearest point assignment block.
// One interface for input items and one for result items; uses gnpa_pkg.
`timescale 1ns / 1ps

interface gnpa_item_if;
  logic                                     valid;
  logic                                     ready;
  logic [gnpa_pkg::FUNC_W-1:0]              func;
  logic [gnpa_pkg::SLOT_W-1:0]              target_slot;
  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] coord_x;
  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] coord_y;
  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] coord_z;

  modport source (output valid, func, target_slot, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, func, target_slot, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface gnpa_result_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [gnpa_pkg::SLOT_W-1:0] chosen_target;
  logic [gnpa_pkg::DIST_W-1:0] distance_sq;

  modport source (output valid, found, chosen_target, distance_sq, input ready);
  modport sink   (input valid, found, chosen_target, distance_sq, output ready);
endinterface

>>> sv/gnpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// Used for the target point store and the used marks; no dependencies.
`timescale 1ns / 1ps

module gnpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/gnpa_ctrl.sv
// Controller of the greedy nearest point assignment block.
// Sequences load, match and clear items; uses gnpa_pkg command and status structs.
`timescale 1ns / 1ps

module gnpa_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [gnpa_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  gnpa_pkg::dp_status_t        status,
  output gnpa_pkg::ctl_cmd_t          cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // State register; reset starts with a clearing pass over the used marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.used_clr = 1'b1;
        cmd.ctr_inc  = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            gnpa_pkg::FUNC_LOAD: begin
              cmd.pt_wr = 1'b1;
            end
            gnpa_pkg::FUNC_MATCH: begin
              cmd.src_load = 1'b1;
              cmd.ctr_clr  = 1'b1;
              state_next   = status.limit_zero ? S_DONE : S_SCAN;
            end
            gnpa_pkg::FUNC_CLEAR: begin
              cmd.ctr_clr = 1'b1;
              state_next  = S_CLEAR;
            end
            default: begin
              // The unused code is dropped without effect.
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.issue   = 1'b1;
        cmd.ctr_inc = 1'b1;
        if (status.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.mark     = status.have;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sv/gnpa_datapath.sv
// Datapath of the greedy nearest point assignment block: stores, address
// counter, distance pipeline, best tracker and result register.
// Depends on gnpa_pkg and gnpa_ram.
`timescale 1ns / 1ps

module gnpa_datapath (
  input  logic                                      clk,
  input  logic                                      rst,
  input  gnpa_pkg::ctl_cmd_t                        cmd,
  output gnpa_pkg::dp_status_t                      status,
  input  logic                                      cfg_we,
  input  logic [gnpa_pkg::COUNT_W-1:0]              cfg_wdata,
  input  logic [gnpa_pkg::SLOT_W-1:0]               in_slot,
  input  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] in_x,
  input  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] in_y,
  input  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] in_z,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic                                      out_found,
  output logic [gnpa_pkg::SLOT_W-1:0]               out_chosen,
  output logic [gnpa_pkg::DIST_W-1:0]               out_dist
);

  localparam int CW = gnpa_pkg::COORD_WIDTH;
  localparam int AW = gnpa_pkg::ADDR_W;

  // Configuration register.
  logic [gnpa_pkg::COUNT_W-1:0] target_count;
  logic [gnpa_pkg::CNT_W-1:0]   limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= '0;
    end else if (cfg_we) begin
      target_count <= cfg_wdata;
    end
  end

  // The scan length saturates at the store depth.
  always_comb begin
    if (32'(target_count) > 32'(gnpa_pkg::TARGET_DEPTH)) begin
      limit = gnpa_pkg::CNT_W'(gnpa_pkg::TARGET_DEPTH);
    end else begin
      limit = gnpa_pkg::CNT_W'(target_count);
    end
  end

  // Address counter shared by the clearing pass and the scan.
  logic [AW-1:0] ctr;

  always_ff @(posedge clk) begin
    if (rst || cmd.ctr_clr) begin
      ctr <= '0;
    end else if (cmd.ctr_inc) begin
      ctr <= ctr + 1'b1;
    end
  end

  // Source point of the current match.
  logic signed [CW-1:0] src_x, src_y, src_z;

  always_ff @(posedge clk) begin
    if (cmd.src_load) begin
      src_x <= gnpa_pkg::sext_coord(in_x);
      src_y <= gnpa_pkg::sext_coord(in_y);
      src_z <= gnpa_pkg::sext_coord(in_z);
    end
  end

  // Target point store; a load beyond the depth is dropped.
  logic                     pt_we;
  logic [gnpa_pkg::PT_W-1:0] pt_wdata, pt_rdata;

  assign pt_we    = cmd.pt_wr && (32'(in_slot) < 32'(gnpa_pkg::TARGET_DEPTH));
  assign pt_wdata = {gnpa_pkg::sext_coord(in_x), gnpa_pkg::sext_coord(in_y),
                     gnpa_pkg::sext_coord(in_z)};

  gnpa_ram #(
    .WIDTH (gnpa_pkg::PT_W),
    .DEPTH (gnpa_pkg::TARGET_DEPTH)
  ) u_points (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (AW'(in_slot)),
    .wr_data (pt_wdata),
    .rd_addr (ctr),
    .rd_data (pt_rdata)
  );

  // Used marks: cleared by the sweep, set for the chosen target.
  logic          have;
  logic [AW-1:0] best_idx;
  logic          used_we;
  logic [AW-1:0] used_waddr;
  logic          used_rdata;

  assign used_we    = cmd.used_clr || cmd.mark;
  assign used_waddr = cmd.mark ? best_idx : ctr;

  gnpa_ram #(
    .WIDTH (1),
    .DEPTH (gnpa_pkg::TARGET_DEPTH)
  ) u_used (
    .clk     (clk),
    .wr_en   (used_we),
    .wr_addr (used_waddr),
    .wr_data (cmd.mark),
    .rd_addr (ctr),
    .rd_data (used_rdata)
  );

  // Pipeline stage valids.
  logic p1, p2, p3, p4;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= 1'b0;
      p2 <= 1'b0;
      p3 <= 1'b0;
      p4 <= 1'b0;
    end else begin
      p1 <= cmd.issue;
      p2 <= p1;
      p3 <= p2;
      p4 <= p3;
    end
  end

  // Stage 1: store data arrives; form the coordinate differences.
  logic [AW-1:0]            idx1, idx2, idx3, idx4;
  logic                     used2, used3, used4;
  logic signed [CW-1:0]     tx, ty, tz;
  logic signed [gnpa_pkg::DIFF_W-1:0] dx, dy, dz;

  assign tx = pt_rdata[3*CW-1:2*CW];
  assign ty = pt_rdata[2*CW-1:CW];
  assign tz = pt_rdata[CW-1:0];

  always_ff @(posedge clk) begin
    idx1  <= ctr;
    idx2  <= idx1;
    used2 <= used_rdata;
    dx    <= gnpa_pkg::DIFF_W'(src_x) - gnpa_pkg::DIFF_W'(tx);
    dy    <= gnpa_pkg::DIFF_W'(src_y) - gnpa_pkg::DIFF_W'(ty);
    dz    <= gnpa_pkg::DIFF_W'(src_z) - gnpa_pkg::DIFF_W'(tz);
  end

  // Stage 2: square each difference.
  logic signed [gnpa_pkg::SQ_W-1:0] prod_x, prod_y, prod_z;
  logic [gnpa_pkg::SQ_W-1:0]        sq_x, sq_y, sq_z;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign prod_z = dz * dz;

  always_ff @(posedge clk) begin
    idx3  <= idx2;
    used3 <= used2;
    sq_x  <= unsigned'(prod_x);
    sq_y  <= unsigned'(prod_y);
    sq_z  <= unsigned'(prod_z);
  end

  // Stage 3: sum of the three squares.
  logic [gnpa_pkg::SUM_W-1:0] dist4, best_d;

  always_ff @(posedge clk) begin
    idx4  <= idx3;
    used4 <= used3;
    dist4 <= gnpa_pkg::SUM_W'(sq_x) + gnpa_pkg::SUM_W'(sq_y) + gnpa_pkg::SUM_W'(sq_z);
  end

  // Stage 4: keep the nearest unused target; a strict compare keeps the lowest index.
  always_ff @(posedge clk) begin
    if (rst || cmd.src_load) begin
      have <= 1'b0;
    end else if (p4 && !used4 && (!have || dist4 < best_d)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p4 && !used4 && (!have || dist4 < best_d)) begin
      best_idx <= idx4;
      best_d   <= dist4;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found  <= have;
      out_chosen <= have ? gnpa_pkg::SLOT_W'(best_idx) : '0;
      out_dist   <= have ? gnpa_pkg::DIST_W'(best_d) : '0;
    end
  end

  // Status toward the controller.
  assign status.clear_last = (ctr == AW'(gnpa_pkg::TARGET_DEPTH - 1));
  assign status.scan_last  = (gnpa_pkg::CNT_W'(ctr) == limit - 1'b1);
  assign status.limit_zero = (limit == '0);
  assign status.pipe_busy  = p1 || p2 || p3 || p4;
  assign status.out_free   = !out_valid || out_ready;
  assign status.have       = have;

endmodule

>>> sv/greedy_nearest_point_assign.sv
// Greedy nearest point assignment: a store of TARGET_DEPTH target points with
// a used mark each. A load item writes its point and leaves the block idle. A
// match item scans targets 0 to min(target_count, TARGET_DEPTH) - 1 through one
// distance pipeline, one target a cycle from the point store's read port. Its
// result is loaded into the output register once the pipeline has drained, or
// without a scan when the count is zero. The chosen target is marked used as
// the result is loaded, and the next item can be taken in the following cycle.
// A result that is still waiting in the output register holds the block in
// that last step. A clear item sweeps the used marks one entry a cycle; the
// same clearing pass runs after reset, and no item is accepted during it. Load
// and clear items give no result; a match item gives exactly one.
// Depends on gnpa_pkg, gnpa_if, gnpa_ram, gnpa_ctrl and gnpa_datapath.
`timescale 1ns / 1ps

module greedy_nearest_point_assign (
  input  logic                         clk,
  input  logic                         rst,
  gnpa_item_if.sink                    items,
  gnpa_result_if.source                results,
  input  logic                         cfg_we,
  input  logic [gnpa_pkg::COUNT_W-1:0] cfg_wdata
);

  gnpa_pkg::ctl_cmd_t   cmd;
  gnpa_pkg::dp_status_t status;

  // Sequencing of items.
  gnpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_func  (items.func),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Stores, distance pipeline and result register.
  gnpa_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_slot    (items.target_slot),
    .in_x       (items.coord_x),
    .in_y       (items.coord_y),
    .in_z       (items.coord_z),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_found  (results.found),
    .out_chosen (results.chosen_target),
    .out_dist   (results.distance_sq)
  );

endmodule

>>> sv/gnpa_checker.sv
// Port-level checks of the greedy nearest point assignment block.
// Bound to the top level; depends on gnpa_pkg.
`timescale 1ns / 1ps

module gnpa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [gnpa_pkg::FUNC_W-1:0] in_func,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [gnpa_pkg::SLOT_W-1:0] out_chosen,
  input logic [gnpa_pkg::DIST_W-1:0] out_dist
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_chosen) && $stable(out_dist))
    else $error("result changed while stalled");

  // A result without an assigned target carries zero index and distance.
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> out_chosen == '0 && out_dist == '0)
    else $error("empty result carries nonzero fields");

  // The clearing pass after reset blocks items.
  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("item accepted during the reset clearing pass");

  // Match and clear items occupy the block for at least the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_func == gnpa_pkg::FUNC_MATCH
      || in_func == gnpa_pkg::FUNC_CLEAR) |=> !in_ready)
    else $error("item accepted while a match or clear is in progress");

endmodule

bind greedy_nearest_point_assign gnpa_checker u_gnpa_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (items.valid),
  .in_ready   (items.ready),
  .in_func    (items.func),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_found  (results.found),
  .out_chosen (results.chosen_target),
  .out_dist   (results.distance_sq)
);

>>> bench/testbench.sv
// Self-checking bench for the greedy nearest point assignment block.
// Needs gnpa_pkg, the gnpa_item_if / gnpa_result_if interfaces and the block's RTL.
// An in-bench predictor mirrors the target store and checks every match result.
`timescale 1ns / 1ps

module testbench;

  // Code with no function in the block; such items are dropped.
  localparam logic [gnpa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [gnpa_pkg::FIELD_COORD_W-1:0] C_MIN = 16'sh8000;
  localparam logic signed [gnpa_pkg::FIELD_COORD_W-1:0] C_MAX = 16'sh7FFF;

  // Number of store entries loaded for the scan tests.
  localparam int WINDOW = 64;

  // Long enough for a clear sweep or a full scan to finish.
  localparam int SETTLE_CYCLES = gnpa_pkg::TARGET_DEPTH + 32;
  localparam int TIMEOUT_NS    = 40_000_000;

  typedef struct packed {
    logic                        found;
    logic [gnpa_pkg::SLOT_W-1:0] target;
    logic [gnpa_pkg::DIST_W-1:0] dist_sq;
  } match_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [gnpa_pkg::COUNT_W-1:0] cfg_wdata;

  gnpa_item_if   items_ch();
  gnpa_result_if results_ch();

  greedy_nearest_point_assign i_dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: the target store, the used marks and the count register.
  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] tgt_x [gnpa_pkg::TARGET_DEPTH];
  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] tgt_y [gnpa_pkg::TARGET_DEPTH];
  logic signed [gnpa_pkg::FIELD_COORD_W-1:0] tgt_z [gnpa_pkg::TARGET_DEPTH];
  bit                                        used_mark [gnpa_pkg::TARGET_DEPTH];
  logic [gnpa_pkg::COUNT_W-1:0]              active_count = '0;

  match_result_t assignment_q[$];
  match_result_t got_head;
  int            error_count = 0;
  bit            idling_on = 1'b1;
  int            stall_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Updates the predicted store for one accepted item and queues the
  // expected assignment of a match item.
  function automatic void predict_assignment(
      input logic [gnpa_pkg::FUNC_W-1:0]               f,
      input logic [gnpa_pkg::SLOT_W-1:0]               slot,
      input logic signed [gnpa_pkg::FIELD_COORD_W-1:0] x,
      input logic signed [gnpa_pkg::FIELD_COORD_W-1:0] y,
      input logic signed [gnpa_pkg::FIELD_COORD_W-1:0] z);
    int            limit;
    int            best;
    bit            have;
    longint        best_d;
    longint        d;
    longint        dx;
    longint        dy;
    longint        dz;
    match_result_t r;
    case (f)
      gnpa_pkg::FUNC_LOAD: begin
        if (slot < gnpa_pkg::TARGET_DEPTH) begin
          tgt_x[slot] = x;
          tgt_y[slot] = y;
          tgt_z[slot] = z;
        end
      end
      gnpa_pkg::FUNC_CLEAR: begin
        foreach (used_mark[i]) used_mark[i] = 1'b0;
      end
      gnpa_pkg::FUNC_MATCH: begin
        limit  = (active_count > gnpa_pkg::TARGET_DEPTH) ? gnpa_pkg::TARGET_DEPTH
                                                         : int'(active_count);
        have   = 1'b0;
        best   = 0;
        best_d = 0;
        for (int j = 0; j < limit; j++) begin
          if (!used_mark[j]) begin
            dx = longint'(x) - longint'(tgt_x[j]);
            dy = longint'(y) - longint'(tgt_y[j]);
            dz = longint'(z) - longint'(tgt_z[j]);
            d  = dx * dx + dy * dy + dz * dz;
            // Strict compare keeps the lowest index on a tie.
            if (!have || d < best_d) begin
              have   = 1'b1;
              best   = j;
              best_d = d;
            end
          end
        end
        if (have) used_mark[best] = 1'b1;
        r.found   = have;
        r.target  = have ? best[gnpa_pkg::SLOT_W-1:0] : '0;
        r.dist_sq = have ? best_d[gnpa_pkg::DIST_W-1:0] : '0;
        assignment_q = {assignment_q, r};
      end
      default: ;
    endcase
  endfunction

  // Mix of extremes, tiny values that make ties, and full-range values.
  function automatic logic signed [gnpa_pkg::FIELD_COORD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return C_MIN;
    if (pick == 1) return C_MAX;
    if (pick < 5) return gnpa_pkg::FIELD_COORD_W'($urandom_range(0, 4) - 2);
    return gnpa_pkg::FIELD_COORD_W'($urandom());
  endfunction

  // Presents one item, waits for its acceptance and feeds the predictor.
  task automatic send_item(input logic [gnpa_pkg::FUNC_W-1:0]               f,
                           input logic [gnpa_pkg::SLOT_W-1:0]               slot,
                           input logic signed [gnpa_pkg::FIELD_COORD_W-1:0] x,
                           input logic signed [gnpa_pkg::FIELD_COORD_W-1:0] y,
                           input logic signed [gnpa_pkg::FIELD_COORD_W-1:0] z);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      items_ch.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    items_ch.func        = f;
    items_ch.target_slot = slot;
    items_ch.coord_x     = x;
    items_ch.coord_y     = y;
    items_ch.coord_z     = z;
    items_ch.valid       = 1'b1;
    forever begin
      @(posedge clk);
      if (items_ch.ready) break;
    end
    predict_assignment(f, slot, x, y, z);
    @(negedge clk);
  endtask

  // Waits until every match has returned and any clear sweep has finished.
  task automatic drain_and_settle();
    items_ch.valid = 1'b0;
    while (assignment_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [gnpa_pkg::COUNT_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we       = 1'b0;
    active_count = value;
  endtask

  // Count zero from reset and after an explicit write: nothing can be found.
  task automatic test_empty_store();
    send_item(gnpa_pkg::FUNC_MATCH, '0, C_MAX, C_MIN, 16'sd0);
    send_item(gnpa_pkg::FUNC_MATCH, 11'h7FF, C_MIN, C_MAX, C_MAX);
    send_item(FUNC_UNUSED, 11'h7FF, C_MAX, C_MAX, C_MAX);
    send_item(gnpa_pkg::FUNC_CLEAR, '0, 16'sd0, 16'sd0, 16'sd0);
    drain_and_settle();
    write_count('0);
    send_item(gnpa_pkg::FUNC_MATCH, 11'h155, 16'sd1, -16'sd1, 16'sd0);
  endtask

  // Hand-picked points: largest distance, exact hits, a tie, exhaustion.
  task automatic test_directed_points();
    send_item(gnpa_pkg::FUNC_LOAD, 11'd0, C_MIN, C_MIN, C_MIN);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd1, C_MAX, C_MAX, C_MAX);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd2, 16'sd0, 16'sd0, 16'sd0);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd3, 16'sd100, -16'sd100, 16'sd50);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd4, 16'sd0, 16'sd0, 16'sd0);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd5, -16'sd1, -16'sd1, -16'sd1);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd6, 16'sd256, 16'sd256, 16'sd256);
    send_item(gnpa_pkg::FUNC_LOAD, 11'd7, C_MIN, C_MAX, 16'sd0);
    send_item(gnpa_pkg::FUNC_LOAD, 11'h7FF, 16'sd1, 16'sd2, 16'sd3);
    drain_and_settle();
    // Only the most negative corner takes part, so the distance is the largest.
    write_count(12'd1);
    send_item(gnpa_pkg::FUNC_MATCH, '0, C_MAX, C_MAX, C_MAX);
    send_item(gnpa_pkg::FUNC_MATCH, '0, C_MAX, C_MAX, C_MAX);
    send_item(FUNC_UNUSED, 11'd2, 16'sd0, 16'sd0, 16'sd0);
    send_item(gnpa_pkg::FUNC_CLEAR, '0, 16'sd0, 16'sd0, 16'sd0);
    drain_and_settle();
    write_count(12'd8);
    send_item(gnpa_pkg::FUNC_MATCH, '0, C_MAX, C_MAX, C_MAX);
    // Slots 2 and 4 hold the same point; the lower index goes first.
    send_item(gnpa_pkg::FUNC_MATCH, '0, 16'sd0, 16'sd0, 16'sd0);
    send_item(gnpa_pkg::FUNC_MATCH, '0, 16'sd0, 16'sd0, 16'sd0);
    for (int i = 0; i < 6; i++) begin
      send_item(gnpa_pkg::FUNC_MATCH, '0, rand_coord(), rand_coord(), C_MIN);
    end
    send_item(gnpa_pkg::FUNC_CLEAR, '0, 16'sd0, 16'sd0, 16'sd0);
  endtask

  // Fills the low window of the store, then scans it with two counts.
  task automatic test_window_scan();
    drain_and_settle();
    for (int i = 0; i < WINDOW; i++) begin
      send_item(gnpa_pkg::FUNC_LOAD, gnpa_pkg::SLOT_W'(i), rand_coord(), rand_coord(),
                rand_coord());
    end
    drain_and_settle();
    write_count(gnpa_pkg::COUNT_W'(WINDOW));
    for (int i = 0; i < 4; i++) begin
      send_item(gnpa_pkg::FUNC_MATCH, '0, rand_coord(), rand_coord(), rand_coord());
    end
    send_item(gnpa_pkg::FUNC_CLEAR, '0, 16'sd0, 16'sd0, 16'sd0);
    drain_and_settle();
    write_count(gnpa_pkg::COUNT_W'(WINDOW - 24));
    for (int i = 0; i < 3; i++) begin
      send_item(gnpa_pkg::FUNC_MATCH, '0, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Random loads, matches, clears and dropped items under one count setting.
  task automatic test_random_mix(input int count, input int n_items);
    int                          kind;
    int                          sent;
    logic [gnpa_pkg::SLOT_W-1:0] slot;
    drain_and_settle();
    write_count(gnpa_pkg::COUNT_W'(count));
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      slot = ($urandom_range(0, 4) != 0)
             ? gnpa_pkg::SLOT_W'($urandom_range(0, count - 1))
             : gnpa_pkg::SLOT_W'($urandom_range(0, gnpa_pkg::TARGET_DEPTH - 1));
      if (kind < 52) begin
        send_item(gnpa_pkg::FUNC_MATCH, gnpa_pkg::SLOT_W'($urandom()), rand_coord(),
                  rand_coord(), rand_coord());
      end else if (kind < 80) begin
        send_item(gnpa_pkg::FUNC_LOAD, slot, rand_coord(), rand_coord(), rand_coord());
      end else if (kind < 92) begin
        send_item(gnpa_pkg::FUNC_CLEAR, slot, rand_coord(), rand_coord(), rand_coord());
      end else begin
        send_item(FUNC_UNUSED, slot, rand_coord(), rand_coord(), rand_coord());
      end
      if (kind < 92) sent++;
    end
  endtask

  // Result side: random stall bursts while idling is enabled.
  always @(negedge clk) begin
    if (!idling_on) begin
      results_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      results_ch.ready = 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      results_ch.ready = 1'b0;
    end else begin
      results_ch.ready = 1'b1;
    end
  end

  // Compare each accepted result item with the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (assignment_q.size() == 0) begin
        $error("result item with no pending match: found %0d target %0d dist %0d",
               results_ch.found, results_ch.chosen_target, results_ch.distance_sq);
        error_count++;
      end else begin
        got_head = assignment_q.pop_front();
        if (results_ch.found !== got_head.found) begin
          $error("found mismatch: expected %0d, actual %0d", got_head.found, results_ch.found);
          error_count++;
        end
        if (results_ch.chosen_target !== got_head.target) begin
          $error("chosen_target mismatch: expected %0d, actual %0d",
                 got_head.target, results_ch.chosen_target);
          error_count++;
        end
        if (results_ch.distance_sq !== got_head.dist_sq) begin
          $error("distance_sq mismatch: expected %0d, actual %0d",
                 got_head.dist_sq, results_ch.distance_sq);
          error_count++;
        end
      end
    end
  end

  initial begin
    foreach (used_mark[i]) used_mark[i] = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    items_ch.valid       = 1'b0;
    items_ch.func        = gnpa_pkg::FUNC_LOAD;
    items_ch.target_slot = '0;
    items_ch.coord_x     = '0;
    items_ch.coord_y     = '0;
    items_ch.coord_z     = '0;
    results_ch.ready     = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_empty_store();
    test_directed_points();
    test_window_scan();
    test_random_mix(1, 20);
    test_random_mix(3, 25);
    test_random_mix(17, 40);
    test_random_mix(WINDOW, 40);
    // Closing stretch runs at full rate on both sides.
    idling_on = 1'b0;
    test_random_mix(9, 50);

    drain_and_settle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
